/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the UTF-8 decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/u8x_pkg.sv */
// Package with the types and constants of the UTF-8 decoder.
`default_nettype none

package u8x_pkg;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned LenWidth = 3;

   // Error codes carried with every result.
   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_NUL   = 3'd1,
      ERR_LEAD  = 3'd2,
      ERR_CONT  = 3'd3,
      ERR_TRUNC = 3'd4
   } err_type;

   // Result of decoding one request, before classification.
   typedef struct packed {
      logic                valid;
      logic [CpWidth-1:0]  code_point;
      logic [LenWidth-1:0] seq_length;
      err_type             error_code;
   } dec_result_type;

endpackage

`default_nettype wire

/* hdl/u8x_class.sv */
// XML name-start and name-character classification of a code point.
`default_nettype none

module u8x_class
   import u8x_pkg::*;
(
   input  wire logic [CpWidth-1:0] code_point,
   output logic                    name_start,
   output logic                    name_char
);

   // Name-start ranges, all compared in parallel.
   always_comb begin
      name_start = (code_point == 21'h3A)
         || (code_point >= 21'h41    && code_point <= 21'h5A)
         || (code_point == 21'h5F)
         || (code_point >= 21'h61    && code_point <= 21'h7A)
         || (code_point >= 21'hC0    && code_point <= 21'hD6)
         || (code_point >= 21'hD8    && code_point <= 21'hF6)
         || (code_point >= 21'hF8    && code_point <= 21'h2FF)
         || (code_point >= 21'h370   && code_point <= 21'h37D)
         || (code_point >= 21'h37F   && code_point <= 21'h1FFF)
         || (code_point >= 21'h200C  && code_point <= 21'h200D)
         || (code_point >= 21'h2070  && code_point <= 21'h218F)
         || (code_point >= 21'h2C00  && code_point <= 21'h2FEF)
         || (code_point >= 21'h3001  && code_point <= 21'hD7FF)
         || (code_point >= 21'hF900  && code_point <= 21'hFDCF)
         || (code_point >= 21'hFDF0  && code_point <= 21'hFFFD)
         || (code_point >= 21'h10000 && code_point <= 21'hEFFFF);
   end

   // Name characters add digits, hyphen, full stop and combining marks.
   always_comb begin
      name_char = name_start
         || (code_point == 21'h2D)
         || (code_point == 21'h2E)
         || (code_point >= 21'h30   && code_point <= 21'h39)
         || (code_point == 21'hB7)
         || (code_point >= 21'h300  && code_point <= 21'h36F)
         || (code_point >= 21'h203F && code_point <= 21'h2040);
   end

endmodule

`default_nettype wire

/* hdl/u8x_decode.sv */
// UTF-8 sequence state and single-byte decode step.
`default_nettype none

module u8x_decode
   import u8x_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output dec_result_type  result
);

   logic [CpWidth-1:0]  partial_value_ff, partial_value_in;
   logic [1:0]          bytes_pending_ff, bytes_pending_in;
   logic [LenWidth-1:0] sequence_bytes_ff, sequence_bytes_in;
   logic [CpWidth-1:0]  shifted_value;
   logic [1:0]          pending_dec;

   assign shifted_value = {partial_value_ff[CpWidth-7:0], data_byte[5:0]};
   assign pending_dec   = bytes_pending_ff - 2'd1;

   // Decode one byte against the current sequence state.
   always_comb begin
      partial_value_in  = partial_value_ff;
      bytes_pending_in  = bytes_pending_ff;
      sequence_bytes_in = sequence_bytes_ff;
      result            = '0;
      result.error_code = ERR_NONE;
      if (bytes_pending_ff == 2'd0) begin
         priority if (data_byte == 8'h00) begin
            result.valid      = 1'b1;
            result.error_code = ERR_NUL;
         end else if (data_byte[7] == 1'b0) begin
            result.valid      = 1'b1;
            result.code_point = {14'd0, data_byte[6:0]};
            result.seq_length = 3'd1;
         end else if (data_byte[7:5] == 3'b110) begin
            partial_value_in  = {16'd0, data_byte[4:0]};
            bytes_pending_in  = 2'd1;
            sequence_bytes_in = 3'd2;
         end else if (data_byte[7:4] == 4'b1110) begin
            partial_value_in  = {17'd0, data_byte[3:0]};
            bytes_pending_in  = 2'd2;
            sequence_bytes_in = 3'd3;
         end else if (data_byte[7:3] == 5'b11110) begin
            partial_value_in  = {18'd0, data_byte[2:0]};
            bytes_pending_in  = 2'd3;
            sequence_bytes_in = 3'd4;
         end else begin
            result.valid      = 1'b1;
            result.error_code = ERR_LEAD;
         end
         // A multi-byte lead on the final byte can never complete.
         if (!result.valid && last_byte) begin
            result.valid      = 1'b1;
            result.error_code = ERR_TRUNC;
         end
      end else begin
         priority if (data_byte[7:6] != 2'b10) begin
            result.valid      = 1'b1;
            result.error_code = ERR_CONT;
         end else if (pending_dec == 2'd0) begin
            result.valid      = 1'b1;
            result.code_point = shifted_value;
            result.seq_length = sequence_bytes_ff;
         end else if (last_byte) begin
            result.valid      = 1'b1;
            result.error_code = ERR_TRUNC;
         end else begin
            partial_value_in  = shifted_value;
            bytes_pending_in  = pending_dec;
         end
      end
      // Any result, good or bad, ends the sequence.
      if (result.valid) begin
         partial_value_in  = '0;
         bytes_pending_in  = 2'd0;
         sequence_bytes_in = '0;
      end
   end

   // Sequence state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_value_ff  <= '0;
         bytes_pending_ff  <= 2'd0;
         sequence_bytes_ff <= '0;
      end else if (step) begin
         partial_value_ff  <= partial_value_in;
         bytes_pending_ff  <= bytes_pending_in;
         sequence_bytes_ff <= sequence_bytes_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/utf8_decode_xml_name_class.sv */
// Top level of the UTF-8 to code point decoder with XML name classification.
// The block takes one byte per request and can accept a request in every
// cycle unless the output register is full and stalled, which raises
// req_stall. A byte is captured in an input register, decoded and classified
// in one pass of logic, and its result, if it has one, lands in the output register.
// Lead and intermediate continuation bytes give no result; the byte that
// completes a sequence gives the code point, its length and its name classes.
// A NUL lead, a bad lead, a bad continuation or a sequence cut short by the
// last-byte mark gives an error result with zero payload and restarts the
// decoder. Overlong forms and surrogates are not rejected.
`default_nettype none
`include "assert_macros.svh"

module utf8_decode_xml_name_class
   import u8x_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_last_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CpWidth-1:0]       rsp_code_point,
   output logic [LenWidth-1:0]      rsp_seq_length,
   output logic                     rsp_name_start,
   output logic                     rsp_name_char,
   output logic [2:0]               rsp_error_code
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                advance;
   dec_result_type      dec;
   logic                cls_start, cls_char;
   logic                rsp_valid_ff;
   logic [CpWidth-1:0]  rsp_cp_ff;
   logic [LenWidth-1:0] rsp_len_ff;
   logic                rsp_start_ff, rsp_char_ff;
   logic [2:0]          rsp_err_ff;

   // The held request moves on when the output register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   u8x_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (dec)
   );

   u8x_class u_class (
      .code_point (dec.code_point),
      .name_start (cls_start),
      .name_char  (cls_char)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dec.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cp_ff    <= dec.code_point;
         rsp_len_ff   <= dec.seq_length;
         rsp_start_ff <= (dec.error_code == ERR_NONE) && cls_start;
         rsp_char_ff  <= (dec.error_code == ERR_NONE) && cls_char;
         rsp_err_ff   <= dec.error_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;
   assign rsp_seq_length = rsp_len_ff;
   assign rsp_name_start = rsp_start_ff;
   assign rsp_name_char  = rsp_char_ff;
   assign rsp_error_code = rsp_err_ff;

   // Checks on the decoder and its pipeline.
   `ASSERT_CLK(a_err_zero, clock, reset, rsp_valid && (rsp_error_code != ERR_NONE) |-> (rsp_code_point == '0) && (rsp_seq_length == '0) && !rsp_name_char, "error result with payload")
   `ASSERT_CLK(a_ok_len, clock, reset, rsp_valid && (rsp_error_code == ERR_NONE) |-> (rsp_seq_length != '0) && (rsp_seq_length <= 3'd4), "good result with bad length")
   `ASSERT_CLK(a_class, clock, reset, rsp_valid && rsp_name_start |-> rsp_name_char, "name start without name char")
   `ASSERT_CLK(a_hold, clock, reset, in_valid_ff && req_stall |=> in_valid_ff && $stable(in_byte_ff), "held request lost")
   `ASSERT_ALWAYS(a_reset, clock, $past(reset) |-> !rsp_valid && !in_valid_ff, "valid after reset")

endmodule

`default_nettype wire

/* tb/utf8_decode_checker.sv */
`timescale 1ns / 100ps
// Checker for the UTF-8 decoder: predicts results from accepted requests and compares them.
module utf8_decode_checker
   import u8x_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CpWidth-1:0]  rsp_code_point,
   input  logic [LenWidth-1:0] rsp_seq_length,
   input  logic                rsp_name_start,
   input  logic                rsp_name_char,
   input  logic [2:0]          rsp_error_code,
   output int unsigned         mismatch_count,
   output int unsigned         chars_outstanding
);

   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic [LenWidth-1:0] seq_length;
      logic                name_start;
      logic                name_char;
      err_type             error_code;
   } decoded_char_type;

   // Predicted results, oldest first.
   decoded_char_type expected_chars[$];

   // Predictor copy of the decoder state.
   logic [CpWidth-1:0]  gathered_bits;
   logic [1:0]          conts_due;
   logic [LenWidth-1:0] char_len;

   int unsigned fail_tally = 0;

   // Characters allowed at the start of an XML name.
   function automatic logic may_start_name(input logic [CpWidth-1:0] cp);
      return cp inside {21'h3A, [21'h41:21'h5A], 21'h5F, [21'h61:21'h7A],
                        [21'hC0:21'hD6], [21'hD8:21'hF6], [21'hF8:21'h2FF],
                        [21'h370:21'h37D], [21'h37F:21'h1FFF], [21'h200C:21'h200D],
                        [21'h2070:21'h218F], [21'h2C00:21'h2FEF], [21'h3001:21'hD7FF],
                        [21'hF900:21'hFDCF], [21'hFDF0:21'hFFFD], [21'h10000:21'hEFFFF]};
   endfunction

   // Characters allowed anywhere inside an XML name.
   function automatic logic may_continue_name(input logic [CpWidth-1:0] cp);
      return may_start_name(cp) ||
             cp inside {21'h2D, 21'h2E, [21'h30:21'h39], 21'hB7,
                        [21'h300:21'h36F], [21'h203F:21'h2040]};
   endfunction

   task automatic restart_decoder();
      gathered_bits = '0;
      conts_due     = 2'd0;
      char_len      = '0;
   endtask

   task automatic expect_char(input logic [CpWidth-1:0] cp, input logic [LenWidth-1:0] len);
      decoded_char_type c;
      c.code_point = cp;
      c.seq_length = len;
      c.name_start = may_start_name(cp);
      c.name_char  = may_continue_name(cp);
      c.error_code = ERR_NONE;
      expected_chars.push_back(c);
      restart_decoder();
   endtask

   // An error carries a zero payload and sends the decoder back to its idle state.
   task automatic expect_error(input err_type code);
      decoded_char_type c;
      c = '0;
      c.error_code = code;
      expected_chars.push_back(c);
      restart_decoder();
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic lst);
      if (conts_due == 2'd0) begin
         // Lead position: plain ASCII completes at once, a multi-byte lead opens a sequence.
         if (b == 8'h00) begin
            expect_error(ERR_NUL);
         end else if (!b[7]) begin
            expect_char({14'd0, b[6:0]}, 3'd1);
         end else begin
            if (b[7:5] == 3'b110) begin
               gathered_bits = {16'd0, b[4:0]};
               conts_due     = 2'd1;
               char_len      = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
               gathered_bits = {17'd0, b[3:0]};
               conts_due     = 2'd2;
               char_len      = 3'd3;
            end else if (b[7:3] == 5'b11110) begin
               gathered_bits = {18'd0, b[2:0]};
               conts_due     = 2'd3;
               char_len      = 3'd4;
            end
            if (conts_due == 2'd0) begin
               expect_error(ERR_LEAD);
            end else if (lst) begin
               expect_error(ERR_TRUNC);
            end
         end
      end else if (b[7:6] != 2'b10) begin
         expect_error(ERR_CONT);
      end else begin
         // Continuation: shift in six bits; the final one completes the character.
         gathered_bits = {gathered_bits[CpWidth-7:0], b[5:0]};
         conts_due     = conts_due - 2'd1;
         if (conts_due == 2'd0) begin
            expect_char(gathered_bits, char_len);
         end else if (lst) begin
            expect_error(ERR_TRUNC);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      fail_tally++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_char_type want;
      if (reset) begin
         expected_chars.delete();
         restart_decoder();
      end else begin
         // A delivered result is matched against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("result delivered with no prediction waiting");
            end else begin
               want = expected_chars.pop_front();
               check_field("code_point", 32'(rsp_code_point), 32'(want.code_point));
               check_field("seq_length", 32'(rsp_seq_length), 32'(want.seq_length));
               check_field("name_start", 32'(rsp_name_start), 32'(want.name_start));
               check_field("name_char", 32'(rsp_name_char), 32'(want.name_char));
               check_field("error_code", 32'(rsp_error_code), 32'(want.error_code));
            end
         end
         // The request taken at this edge feeds the predictor.
         if (req_valid && !req_stall) begin
            predict_byte(req_data_byte, req_last_byte);
         end
      end
      mismatch_count    <= fail_tally;
      chars_outstanding <= expected_chars.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus, result stalls and verdict.
module tb_top;
   import u8x_pkg::*;

   localparam int unsigned PhaseItems = 450;
   localparam int unsigned HoldCycles = 120;
   localparam int unsigned DrainLimit = 2000;
   localparam int unsigned TailCycles = 8;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_data_byte;
   logic                req_last_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CpWidth-1:0]  rsp_code_point;
   logic [LenWidth-1:0] rsp_seq_length;
   logic                rsp_name_start;
   logic                rsp_name_char;
   logic [2:0]          rsp_error_code;
   int unsigned         mismatch_count;
   int unsigned         chars_outstanding;

   int unsigned items_sent        = 0;
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned hold_requests     = 0;

   // Idle rates of the sender and the receiver in each random phase.
   int unsigned sender_pcts [3]   = '{36, 49, 0};
   int unsigned receiver_pcts [3] = '{49, 36, 0};

   // Code points where the name classes change; stimulus lands on and beside them.
   int unsigned class_edges [39] = '{
      'h2D, 'h2E, 'h30, 'h39, 'h3A, 'h41, 'h5A, 'h5F, 'h61, 'h7A,
      'hB7, 'hC0, 'hD6, 'hD8, 'hF6, 'hF8, 'h2FF, 'h300, 'h36F, 'h370,
      'h37D, 'h37F, 'h1FFF, 'h200C, 'h200D, 'h203F, 'h2040, 'h2070, 'h218F, 'h2C00,
      'h2FEF, 'h3001, 'hD7FF, 'hF900, 'hFDCF, 'hFDF0, 'hFFFD, 'h10000, 'hEFFFF};

   // Opening requests as {last_byte, data_byte}.
   logic [8:0] opening_bytes [24] = '{
      // ASCII letter, NUL lead, stray continuation as lead, invalid lead.
      9'h041, 9'h000, 9'h080, 9'h0FF,
      // Two, three and four byte characters, the last one the largest value.
      9'h0C3, 9'h0A9,
      9'h0E3, 9'h080, 9'h081,
      9'h0F0, 9'h090, 9'h080, 9'h080,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      // Multi-byte lead marked as the last byte.
      9'h1C2,
      // Continuation that is not 10xxxxxx, then a NUL as continuation.
      9'h0E2, 9'h041,
      9'h0C2, 9'h000,
      // Good continuation marked last while another is still due.
      9'h0E2, 9'h180};

   utf8_decode_xml_name_class dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data_byte,
      .req_last_byte,
      .rsp_valid,
      .rsp_stall,
      .rsp_code_point,
      .rsp_seq_length,
      .rsp_name_start,
      .rsp_name_char,
      .rsp_error_code
   );

   utf8_decode_checker u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data_byte,
      .req_last_byte,
      .rsp_valid,
      .rsp_stall,
      .rsp_code_point,
      .rsp_seq_length,
      .rsp_name_start,
      .rsp_name_char,
      .rsp_error_code,
      .mismatch_count,
      .chars_outstanding
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the run hangs.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, and a long hold-off whenever one is asked for.
   initial begin : receiver
      int unsigned holds_served;
      holds_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // Offers one request, after idle cycles drawn one at a time, and returns once it is taken.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Mostly whole characters with random content, the rest broken sequences and noise.
   task automatic send_random_item();
      logic [7:0]  seq [4];
      logic [3:0]  last_mask;
      logic [20:0] cp;
      int unsigned len;
      int unsigned k;
      if ($urandom_range(99) < 75) begin
         if ($urandom_range(1)) begin
            cp  = 21'(class_edges[$urandom_range($size(class_edges) - 1)]
                      + $urandom_range(2) - 1);
            len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
         end else begin
            // Any bits for the chosen length, overlong forms included.
            len = $urandom_range(4, 1);
            cp  = 21'((len == 1) ? $urandom_range('h7F, 1) :
                      (len == 2) ? $urandom_range('h7FF) :
                      (len == 3) ? $urandom_range('hFFFF) : $urandom_range('h1FFFFF));
         end
         case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
               seq[0] = {3'b110, cp[10:6]};
               seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
               seq[0] = {4'b1110, cp[15:12]};
               seq[1] = {2'b10, cp[11:6]};
               seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
               seq[0] = {5'b11110, cp[20:18]};
               seq[1] = {2'b10, cp[17:12]};
               seq[2] = {2'b10, cp[11:6]};
               seq[3] = {2'b10, cp[5:0]};
            end
         endcase
         last_mask = 4'd0;
         if ($urandom_range(15) == 0) last_mask[len-1] = 1'b1;
         // Now and then the sequence is cut short or a continuation byte is spoilt.
         if (len > 1 && $urandom_range(9) == 0) begin
            if ($urandom_range(1)) begin
               last_mask[$urandom_range(len - 2)] = 1'b1;
            end else begin
               seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
            end
         end
         for (k = 0; k < len; k++) send_byte(seq[k], last_mask[k]);
      end else begin
         send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned drained;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, with no idling on either side.
      foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);

      // Random phases; the first one starts with a long hold-off of the results.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = sender_pcts[phase];
         receiver_idle_pct <= receiver_pcts[phase];
         if (phase == 0) hold_requests <= hold_requests + 1;
         target = items_sent + PhaseItems;
         while (items_sent < target) send_random_item();
      end
      req_valid <= 1'b0;

      // Let the outstanding results drain, then allow for the pipeline depth.
      drained = 0;
      do begin
         @(posedge clock);
         drained++;
      end while (chars_outstanding != 0 && drained < DrainLimit);
      repeat (TailCycles) @(posedge clock);

      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/u8x_pkg.sv
hdl/u8x_class.sv
hdl/u8x_decode.sv
hdl/utf8_decode_xml_name_class.sv
tb/utf8_decode_checker.sv
tb/tb_top.sv
